// File: rtl/ecpa_pkg.sv
// ecpa_pkg: shared types and opcodes for the elliptic-curve point arithmetic block
// no dependencies
`timescale 1ns / 1ps
package ecpa_pkg;
    typedef enum logic [1:0] {
        t_OP_ADD = 2'd0,
        t_OP_SUB = 2'd1,
        t_OP_MUL = 2'd2,
        t_OP_INV = 2'd3
    } t_fop;

    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_CURVE_A = 1'b1;
endpackage

// File: rtl/ecpa_fp_unit.sv
// ecpa_fp_unit: bit-serial field unit, add/sub done in the cycle after start, multiply
// one bit per cycle and inverse by a serial gcd; depends on ecpa_pkg
`timescale 1ns / 1ps
module ecpa_fp_unit #(
    parameter int W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  ecpa_pkg::t_fop       i_op,
    input  logic [W-1:0]         i_a,
    input  logic [W-1:0]         i_b,
    input  logic [W-1:0]         i_p,
    output logic                 o_done,
    output logic [W-1:0]         o_res
);
    // inverse as a^(p-2) would need primality; use binary extended gcd, one step a cycle
    // halving a coefficient mod p needs an odd p; with an even p only subtract steps run
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_INV} t_st;
    t_st          r_st;
    logic [W-1:0] r_acc, r_a, r_b, r_res;
    logic [W:0]   r_u, r_v;
    logic [W-1:0] r_x1, r_x2;
    logic         r_done;

    function automatic logic [W-1:0] f_add(logic [W-1:0] a, logic [W-1:0] b,
                                           logic [W-1:0] p);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p}) s = s - {1'b0, p};
        return s[W-1:0];
    endfunction
    function automatic logic [W-1:0] f_sub(logic [W-1:0] a, logic [W-1:0] b,
                                           logic [W-1:0] p);
        return (a >= b) ? a - b : a + (p - b);
    endfunction
    function automatic logic [W-1:0] f_half(logic [W-1:0] x, logic [W-1:0] p);
        logic [W:0] s;
        s = x[0] ? ({1'b0, x} + {1'b0, p}) : {1'b0, x};
        return s[W:1];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        case (i_op)
                            ecpa_pkg::t_OP_ADD: begin
                                r_res <= f_add(i_a, i_b, i_p); r_done <= 1'b1;
                            end
                            ecpa_pkg::t_OP_SUB: begin
                                r_res <= f_sub(i_a, i_b, i_p); r_done <= 1'b1;
                            end
                            ecpa_pkg::t_OP_MUL: begin
                                r_acc <= '0; r_a <= i_a; r_b <= i_b; r_st <= S_MUL;
                            end
                            default: begin
                                // invariants: x1*a = u, x2*a = v (mod p)
                                r_u  <= {1'b0, i_a}; r_v <= {1'b0, i_p};
                                r_x1 <= {{(W-1){1'b0}}, 1'b1}; r_x2 <= '0;
                                r_st <= S_INV;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    if (r_b == '0) begin
                        r_res <= r_acc; r_done <= 1'b1; r_st <= S_IDLE;
                    end else begin
                        if (r_b[0]) r_acc <= f_add(r_acc, r_a, i_p);
                        r_a <= f_add(r_a, r_a, i_p);
                        r_b <= r_b >> 1;
                    end
                end
                S_INV: begin
                    if (r_u == '0 || r_v == '0) begin
                        // gcd sits in the nonzero one; unit only when it is 1
                        if (r_u == {{W{1'b0}}, 1'b1}) r_res <= r_x1;
                        else if (r_v == {{W{1'b0}}, 1'b1}) r_res <= r_x2;
                        else r_res <= '0;
                        r_done <= 1'b1; r_st <= S_IDLE;
                    end else if (!r_u[0] && i_p[0]) begin
                        r_u <= r_u >> 1; r_x1 <= f_half(r_x1, i_p);
                    end else if (!r_v[0] && i_p[0]) begin
                        r_v <= r_v >> 1; r_x2 <= f_half(r_x2, i_p);
                    end else if (r_u >= r_v) begin
                        r_u <= r_u - r_v; r_x1 <= f_sub(r_x1, r_x2, i_p);
                    end else begin
                        r_v <= r_v - r_u; r_x2 <= f_sub(r_x2, r_x1, i_p);
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

// File: rtl/ec_point_add_scalar_mul.sv
// ec_point_add_scalar_mul: affine point add/double and scalar multiply over GF(p)
// depends on ecpa_pkg and ecpa_fp_unit
// five reduction passes by repeated subtraction of p, then one point addition
// (addition) or k-1 of them (scalar k), then the result register is loaded
// with an even p the field inverse is a subtractive gcd of up to p steps
// one item at a time; ready returns once the sequencer idles and the result is taken
// reset (synchronous, active low) sets modulus 23, curve_a 0 and idles the sequencer
`timescale 1ns / 1ps
module ec_point_add_scalar_mul #(
    parameter int COORD_BITS  = 8,
    parameter int SCALAR_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [7:0]             i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_req_type,
    input  logic [COORD_BITS-1:0]  i_x1,
    input  logic [COORD_BITS-1:0]  i_y1,
    input  logic [COORD_BITS-1:0]  i_x2,
    input  logic [COORD_BITS-1:0]  i_y2,
    input  logic [SCALAR_BITS-1:0] i_scalar,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COORD_BITS-1:0]  o_rx,
    output logic [COORD_BITS-1:0]  o_ry,
    output logic                   o_at_infinity
);
    localparam int W  = COORD_BITS;
    // one spare bit so the addition count of 2 fits for any scalar width
    localparam int KW = SCALAR_BITS + 1;

    // config registers, 8 bits wide per register map
    logic [7:0] r_modulus, r_curve_a;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= 8'd23;
            r_curve_a <= 8'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ecpa_pkg::CFG_MODULUS) r_modulus <= i_cfg_data;
            else r_curve_a <= i_cfg_data;
        end
    end

    // effective modulus: register masked to coordinate width, floor of 3
    logic [W-1:0] w_pm, w_p;
    always_comb begin
        w_pm = '0;
        for (int i = 0; i < W && i < 8; i++) w_pm[i] = r_modulus[i];
        w_p = (w_pm < W'(3)) ? W'(3) : w_pm;
    end

    // shared field unit
    logic             r_fs;
    ecpa_pkg::t_fop   r_fop;
    logic [W-1:0]     r_fa, r_fb;
    logic             w_fdone;
    logic [W-1:0]     w_fres;

    ecpa_fp_unit #(.W(W)) u_fp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_fs), .i_op(r_fop),
        .i_a(r_fa), .i_b(r_fb), .i_p(w_p), .o_done(w_fdone), .o_res(w_fres)
    );

    // sequencer states: reduce operands, then add steps as a microprogram
    typedef enum logic [4:0] {
        S_IDLE, S_RED, S_ADDCHK, S_EQY, S_D1, S_D2, S_D3, S_D4, S_D5,
        S_C1, S_C2, S_C3, S_M, S_X1, S_X2, S_X3, S_Y1, S_Y2, S_Y3,
        S_NEXT, S_OUT, S_WAITF
    } t_st;

    t_st          r_st, r_ret;
    logic [W-1:0] r_px, r_py, r_qx, r_qy, r_rx, r_ry, r_a, r_t, r_m, r_x3;
    logic         r_rinf, r_mul;
    logic [KW-1:0] r_k;
    logic [2:0]   r_ridx;
    logic [W-1:0] r_red;
    logic         r_ov;
    logic [W-1:0] r_ox, r_oy;
    logic         r_oi;

    logic [W-1:0] w_amask;
    always_comb begin
        w_amask = '0;
        for (int i = 0; i < W && i < 8; i++) w_amask[i] = r_curve_a[i];
    end

    // running sum is r_rx/r_ry/r_rinf, added point is r_qx/r_qy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_fs <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_fs <= 1'b0;
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid && !r_ov) begin
                        r_px <= i_x1; r_py <= i_y1; r_qx <= i_x2; r_qy <= i_y2;
                        r_a  <= w_amask; r_mul <= i_req_type; r_k <= {1'b0, i_scalar};
                        r_ridx <= 3'd0; r_red <= i_x1;
                        r_st <= S_RED;
                    end
                end
                S_RED: begin
                    if (r_red >= w_p) begin
                        r_red <= r_red - w_p;
                    end else begin
                        case (r_ridx)
                            3'd0: r_px <= r_red;
                            3'd1: r_py <= r_red;
                            3'd2: r_qx <= r_red;
                            3'd3: r_qy <= r_red;
                            default: r_a <= r_red;
                        endcase
                        if (r_ridx == 3'd4) begin
                            if (r_mul) begin
                                // running sum = P, added point = P
                                r_rx <= r_px; r_ry <= r_py; r_rinf <= 1'b0;
                                r_qx <= r_px; r_qy <= r_py;
                                if (r_k == '0) begin
                                    r_rinf <= 1'b1; r_st <= S_OUT;
                                end else begin
                                    r_st <= S_NEXT;
                                end
                            end else begin
                                r_rx <= r_px; r_ry <= r_py; r_rinf <= 1'b0;
                                r_k <= KW'(2);
                                r_st <= S_NEXT;
                            end
                        end else begin
                            r_ridx <= r_ridx + 3'd1;
                            case (r_ridx)
                                3'd0: r_red <= r_py;
                                3'd1: r_red <= r_qx;
                                3'd2: r_red <= r_qy;
                                default: r_red <= r_a;
                            endcase
                        end
                    end
                end
                S_NEXT: begin
                    // one more addition while k > 1
                    if (r_k <= KW'(1)) begin
                        r_st <= S_OUT;
                    end else if (r_rinf) begin
                        r_rx <= r_qx; r_ry <= r_qy; r_rinf <= 1'b0;
                        r_k <= r_k - KW'(1);
                    end else begin
                        r_k <= r_k - KW'(1);
                        r_fop <= ecpa_pkg::t_OP_ADD; r_fa <= r_ry; r_fb <= r_qy;
                        r_fs <= 1'b1; r_ret <= S_ADDCHK; r_st <= S_WAITF;
                    end
                end
                S_WAITF: begin
                    if (w_fdone) begin
                        r_t  <= w_fres;
                        r_st <= r_ret;
                    end
                end
                S_ADDCHK: begin
                    if (r_rx == r_qx && r_t == '0) begin
                        r_rinf <= 1'b1; r_st <= S_NEXT;
                    end else if (r_rx == r_qx && r_ry == r_qy) begin
                        // doubling: x^2
                        r_fop <= ecpa_pkg::t_OP_MUL; r_fa <= r_rx; r_fb <= r_rx;
                        r_fs <= 1'b1; r_ret <= S_D1; r_st <= S_WAITF;
                    end else begin
                        r_fop <= ecpa_pkg::t_OP_SUB; r_fa <= r_qx; r_fb <= r_rx;
                        r_fs <= 1'b1; r_ret <= S_C1; r_st <= S_WAITF;
                    end
                end
                S_D1: begin
                    r_fop <= ecpa_pkg::t_OP_MUL; r_fa <= W'(3); r_fb <= r_t;
                    r_fs <= 1'b1; r_ret <= S_D2; r_st <= S_WAITF;
                end
                S_D2: begin
                    r_fop <= ecpa_pkg::t_OP_ADD; r_fa <= r_t; r_fb <= r_a;
                    r_fs <= 1'b1; r_ret <= S_D3; r_st <= S_WAITF;
                end
                S_D3: begin
                    r_m <= r_t;
                    r_fop <= ecpa_pkg::t_OP_ADD; r_fa <= r_ry; r_fb <= r_ry;
                    r_fs <= 1'b1; r_ret <= S_D4; r_st <= S_WAITF;
                end
                S_D4: begin
                    r_fop <= ecpa_pkg::t_OP_INV; r_fa <= r_t; r_fb <= '0;
                    r_fs <= 1'b1; r_ret <= S_M; r_st <= S_WAITF;
                end
                S_C1: begin
                    r_fop <= ecpa_pkg::t_OP_INV; r_fa <= r_t; r_fb <= '0;
                    r_fs <= 1'b1; r_ret <= S_C2; r_st <= S_WAITF;
                end
                S_C2: begin
                    r_x3 <= r_t;
                    r_fop <= ecpa_pkg::t_OP_SUB; r_fa <= r_qy; r_fb <= r_ry;
                    r_fs <= 1'b1; r_ret <= S_C3; r_st <= S_WAITF;
                end
                S_C3: begin
                    // numerator in r_t, inverse parked in r_x3
                    r_m <= r_t; r_t <= r_x3; r_st <= S_M;
                end
                S_M: begin
                    r_fop <= ecpa_pkg::t_OP_MUL; r_fa <= r_m; r_fb <= r_t;
                    r_fs <= 1'b1; r_ret <= S_D5; r_st <= S_WAITF;
                end
                S_D5: begin
                    r_m <= r_t;
                    r_fop <= ecpa_pkg::t_OP_MUL; r_fa <= r_t; r_fb <= r_t;
                    r_fs <= 1'b1; r_ret <= S_X1; r_st <= S_WAITF;
                end
                S_X1: begin
                    r_fop <= ecpa_pkg::t_OP_SUB; r_fa <= r_t; r_fb <= r_rx;
                    r_fs <= 1'b1; r_ret <= S_X2; r_st <= S_WAITF;
                end
                S_X2: begin
                    r_fop <= ecpa_pkg::t_OP_SUB; r_fa <= r_t; r_fb <= r_qx;
                    r_fs <= 1'b1; r_ret <= S_X3; r_st <= S_WAITF;
                end
                S_X3: begin
                    r_x3 <= r_t;
                    r_fop <= ecpa_pkg::t_OP_SUB; r_fa <= r_rx; r_fb <= r_t;
                    r_fs <= 1'b1; r_ret <= S_Y1; r_st <= S_WAITF;
                end
                S_Y1: begin
                    r_fop <= ecpa_pkg::t_OP_MUL; r_fa <= r_m; r_fb <= r_t;
                    r_fs <= 1'b1; r_ret <= S_Y2; r_st <= S_WAITF;
                end
                S_Y2: begin
                    r_fop <= ecpa_pkg::t_OP_SUB; r_fa <= r_t; r_fb <= r_ry;
                    r_fs <= 1'b1; r_ret <= S_Y3; r_st <= S_WAITF;
                end
                S_Y3: begin
                    r_rx <= r_x3; r_ry <= r_t; r_st <= S_NEXT;
                end
                S_OUT: begin
                    if (!r_ov || i_ready) begin
                        r_ox <= r_rinf ? '0 : r_rx;
                        r_oy <= r_rinf ? '0 : r_ry;
                        r_oi <= r_rinf;
                        r_ov <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_ready       = (r_st == S_IDLE) && !r_ov;
    assign o_valid       = r_ov;
    assign o_rx          = r_ox;
    assign o_ry          = r_oy;
    assign o_at_infinity = r_oi;
endmodule
